FILE: hdl/pms_pkg.sv
// ----------------------------------------------------------------------------
// Pointer move slicer package
// Shared types and constants for the pointer move slicer core.
// ----------------------------------------------------------------------------
package pms_pkg;

  localparam int DELTA_W    = 8;
  localparam int DUR_W      = 16;
  localparam int POLL_W     = 8;
  localparam int PACE_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int DIV_N_W    = 20;
  localparam int DIV_D_W    = 12;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_POLL_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PACE_NUM      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PACE_DEN      = 2'd2;

  typedef struct packed {
    logic signed [DELTA_W-1:0] delta_x;
    logic signed [DELTA_W-1:0] delta_y;
    logic [DUR_W-1:0]          duration_ms;
  } pms_in_t;

  typedef struct packed {
    logic signed [DELTA_W-1:0] slice_x;
    logic signed [DELTA_W-1:0] slice_y;
    logic                      send_report;
    logic [DUR_W-1:0]          due_ms;
    logic                      last_slice;
  } pms_out_t;

  typedef struct packed {
    logic [POLL_W-1:0] poll_interval_ms;
    logic [PACE_W-1:0] pace_numerator;
    logic [PACE_W-1:0] pace_denominator;
  } pms_cfg_t;

  typedef struct packed {
    logic                neg_x;
    logic                neg_y;
    logic [DELTA_W-1:0]  mag_x;
    logic [DELTA_W-1:0]  mag_y;
    logic [DUR_W-1:0]    duration_ms;
    logic                zero_move;
    logic [DELTA_W-1:0]  pre_steps;
  } pms_job_t;

endpackage

FILE: hdl/pointer_move_slicer_core.sv
// ----------------------------------------------------------------------------
// Pointer move slicer core
// Splits a recorded pointer move into paced report slices.
// ----------------------------------------------------------------------------
// A move (delta_x, delta_y, duration_ms) is transferred in on a cycle where
// start is high and busy is low. Moves wait in a two-entry queue, so busy
// rises only when that queue is full.
// Each move yields one or more slices. A slice is shown on the slice port for
// exactly one cycle with slice_valid high; the receiver cannot stall it.
// A move with no motion gives its single slice in the cycle after it leaves
// the queue. Any other move first runs four divisions on a shared one-bit-
// per-cycle divider (pacing cap, then the x, y and time steps), one after
// another, before its first slice. Its slices then come out on consecutive
// cycles, one per step, with at most MAX_STEPS slices. A move therefore
// occupies the back end for its four divisions and then its slices.
// The configuration registers are written through cfg_we, cfg_index and
// cfg_data; the user must write them only while no move is in flight, and
// the block does not enforce this. Reset empties the queue, stops any move
// in progress and sets all three registers to 1.
// ----------------------------------------------------------------------------
module pointer_move_slicer_core import pms_pkg::*; #(
  parameter int MAX_STEPS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  pms_in_t               move,
  output logic                  slice_valid,
  output pms_out_t              slice,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  pms_cfg_t cfg;
  pms_job_t front_job;
  pms_job_t head;
  logic     full;
  logic     empty;
  logic     pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.poll_interval_ms <= POLL_W'(1);
      cfg.pace_numerator   <= PACE_W'(1);
      cfg.pace_denominator <= PACE_W'(1);
    end else if (cfg_we) begin
      if (cfg_index == CFG_POLL_INTERVAL) begin
        cfg.poll_interval_ms <= cfg_data[POLL_W-1:0];
      end else if (cfg_index == CFG_PACE_NUM) begin
        cfg.pace_numerator <= cfg_data[PACE_W-1:0];
      end else if (cfg_index == CFG_PACE_DEN) begin
        cfg.pace_denominator <= cfg_data[PACE_W-1:0];
      end
    end
  end

  assign busy = full;

  pms_front u_front (
    .move (move),
    .job  (front_job)
  );

  pms_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (start),
    .push_data (front_job),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  pms_back #(
    .MAX_STEPS (MAX_STEPS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head        (head),
    .empty       (empty),
    .pop         (pop),
    .slice_valid (slice_valid),
    .slice       (slice)
  );

endmodule

FILE: hdl/pms_front.sv
// ----------------------------------------------------------------------------
// Pointer move slicer front end
// Classifies an incoming move and forms the job that the back end carries out.
// ----------------------------------------------------------------------------
module pms_front import pms_pkg::*; (
  input  pms_in_t  move,
  output pms_job_t job
);

  logic [DELTA_W-1:0] mag_x;
  logic [DELTA_W-1:0] mag_y;
  logic [DELTA_W-1:0] span;
  logic [DELTA_W-1:0] pre;

  always_comb begin
    mag_x = move.delta_x[DELTA_W-1] ? DELTA_W'(-move.delta_x) : DELTA_W'(move.delta_x);
    mag_y = move.delta_y[DELTA_W-1] ? DELTA_W'(-move.delta_y) : DELTA_W'(move.delta_y);
    span  = (mag_x > mag_y) ? mag_x : mag_y;
    if (move.duration_ms < DUR_W'(span)) begin
      pre = DELTA_W'(move.duration_ms);
    end else begin
      pre = span;
    end
    if (pre == '0) begin
      pre = DELTA_W'(1);
    end
    job.neg_x       = move.delta_x[DELTA_W-1];
    job.neg_y       = move.delta_y[DELTA_W-1];
    job.mag_x       = mag_x;
    job.mag_y       = mag_y;
    job.duration_ms = move.duration_ms;
    job.zero_move   = (span == '0);
    job.pre_steps   = pre;
  end

endmodule

FILE: hdl/pms_queue.sv
// ----------------------------------------------------------------------------
// Pointer move slicer job queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module pms_queue import pms_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  pms_job_t push_data,
  input  logic     pop,
  output pms_job_t head,
  output logic     full,
  output logic     empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pms_job_t         entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if ((push && !full) && !(pop && !empty)) begin
        count <= count + CNT_W'(1);
      end else if (!(push && !full) && (pop && !empty)) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

FILE: hdl/pms_div.sv
// ----------------------------------------------------------------------------
// Pointer move slicer divider
// Restoring unsigned divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pms_div import pms_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DIV_N_W-1:0] dividend,
  input  logic [DIV_D_W-1:0] divisor,
  output logic               done,
  output logic [DIV_N_W-1:0] quotient,
  output logic [DIV_D_W-1:0] remainder
);

  localparam int CNT_W = $clog2(DIV_N_W + 1);

  logic [DIV_N_W-1:0] quo;
  logic [DIV_D_W-1:0] rem;
  logic [DIV_D_W-1:0] dsr;
  logic [CNT_W-1:0]   cnt;
  logic               running;
  logic [DIV_D_W:0]   trial;
  logic               fits;
  logic [DIV_D_W:0]   diff;

  always_comb begin
    trial = {rem, quo[DIV_N_W-1]};
    fits  = (trial >= {1'b0, dsr});
    diff  = trial - {1'b0, dsr};
  end

  assign quotient  = quo;
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (running) begin
      quo <= {quo[DIV_N_W-2:0], fits};
      rem <= fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
      done    <= 1'b0;
    end else begin
      done <= !start && running && (cnt == CNT_W'(1));
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(DIV_N_W);
      end else if (running) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: hdl/pms_back.sv
// ----------------------------------------------------------------------------
// Pointer move slicer back end
// Works out the step count and per-slice quotients, then emits the slices.
// ----------------------------------------------------------------------------
module pms_back import pms_pkg::*; #(
  parameter int MAX_STEPS = 64
) (
  input  logic     clk,
  input  logic     rst,
  input  pms_cfg_t cfg,
  input  pms_job_t head,
  input  logic     empty,
  output logic     pop,
  output logic     slice_valid,
  output pms_out_t slice
);

  localparam int STEP_W = $clog2(MAX_STEPS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_CAP,
    S_DIV_X,
    S_DIV_Y,
    S_DIV_D,
    S_SLICE
  } state_t;

  state_t             state;
  pms_job_t           job;
  logic [STEP_W-1:0]  steps;
  logic [STEP_W-1:0]  k;
  logic [DELTA_W-1:0] q0x;
  logic [DELTA_W-1:0] q0y;
  logic [DUR_W-1:0]   q0d;
  logic [STEP_W-1:0]  r0x;
  logic [STEP_W-1:0]  r0y;
  logic [STEP_W-1:0]  r0d;
  logic [STEP_W-1:0]  rx;
  logic [STEP_W-1:0]  ry;
  logic [STEP_W-1:0]  rd;
  logic [DUR_W-1:0]   qd;

  logic               div_start;
  logic               div_start_next;
  logic               slice_valid_next;
  logic               div_done;
  logic [DIV_N_W-1:0] div_dividend;
  logic [DIV_D_W-1:0] div_divisor;
  logic [DIV_N_W-1:0] div_quotient;
  logic [DIV_D_W-1:0] div_remainder;

  logic [POLL_W-1:0]  poll_eff;
  logic [PACE_W-1:0]  num_eff;
  logic [DIV_N_W-1:0] cap_eff;
  logic [DIV_N_W-1:0] lim;
  logic [STEP_W-1:0]  steps_calc;

  logic [STEP_W:0]    sum_x;
  logic [STEP_W:0]    sum_y;
  logic [STEP_W:0]    sum_d;
  logic               carry_x;
  logic               carry_y;
  logic               carry_d;
  logic [DELTA_W-1:0] mag_sx;
  logic [DELTA_W-1:0] mag_sy;
  logic [DELTA_W-1:0] val_x;
  logic [DELTA_W-1:0] val_y;
  logic [DUR_W-1:0]   due_next;

  pms_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  always_comb begin
    poll_eff = (cfg.poll_interval_ms == '0) ? POLL_W'(1) : cfg.poll_interval_ms;
    num_eff  = (cfg.pace_numerator == '0) ? PACE_W'(1) : cfg.pace_numerator;
    unique case (state)
      S_DIV_CAP: begin
        div_dividend = DIV_N_W'(job.duration_ms) * DIV_N_W'(cfg.pace_denominator);
        div_divisor  = DIV_D_W'(poll_eff) * DIV_D_W'(num_eff);
      end
      S_DIV_X: begin
        div_dividend = DIV_N_W'(job.mag_x);
        div_divisor  = DIV_D_W'(steps);
      end
      S_DIV_Y: begin
        div_dividend = DIV_N_W'(job.mag_y);
        div_divisor  = DIV_D_W'(steps);
      end
      S_DIV_D: begin
        div_dividend = DIV_N_W'(job.duration_ms);
        div_divisor  = DIV_D_W'(steps);
      end
      default: begin
        div_dividend = '0;
        div_divisor  = DIV_D_W'(1);
      end
    endcase
  end

  always_comb begin
    div_start_next   = 1'b0;
    slice_valid_next = 1'b0;
    unique case (state)
      S_IDLE: begin
        div_start_next   = !empty && !head.zero_move;
        slice_valid_next = !empty && head.zero_move;
      end
      S_DIV_CAP, S_DIV_X, S_DIV_Y: begin
        div_start_next = div_done;
      end
      S_SLICE: begin
        slice_valid_next = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    cap_eff = (div_quotient == '0) ? DIV_N_W'(1) : div_quotient;
    lim     = cap_eff;
    if (DIV_N_W'(job.pre_steps) < lim) begin
      lim = DIV_N_W'(job.pre_steps);
    end
    if (DIV_N_W'(MAX_STEPS) < lim) begin
      lim = DIV_N_W'(MAX_STEPS);
    end
    steps_calc = lim[STEP_W-1:0];
  end

  always_comb begin
    sum_x    = {1'b0, rx} + {1'b0, r0x};
    sum_y    = {1'b0, ry} + {1'b0, r0y};
    sum_d    = {1'b0, rd} + {1'b0, r0d};
    carry_x  = (sum_x >= {1'b0, steps});
    carry_y  = (sum_y >= {1'b0, steps});
    carry_d  = (sum_d >= {1'b0, steps});
    mag_sx   = q0x + DELTA_W'(carry_x);
    mag_sy   = q0y + DELTA_W'(carry_y);
    val_x    = job.neg_x ? DELTA_W'(-mag_sx) : mag_sx;
    val_y    = job.neg_y ? DELTA_W'(-mag_sy) : mag_sy;
    due_next = qd + q0d + DUR_W'(carry_d);
  end

  assign pop = (state == S_IDLE) && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      div_start   <= 1'b0;
      slice_valid <= 1'b0;
    end else begin
      div_start   <= div_start_next;
      slice_valid <= slice_valid_next;
      unique case (state)
        S_IDLE: begin
          if (!empty) begin
            job <= head;
            if (head.zero_move) begin
              slice.slice_x     <= '0;
              slice.slice_y     <= '0;
              slice.send_report <= 1'b0;
              slice.due_ms      <= head.duration_ms;
              slice.last_slice  <= 1'b1;
            end else begin
              state <= S_DIV_CAP;
            end
          end
        end
        S_DIV_CAP: begin
          if (div_done) begin
            steps <= steps_calc;
            state <= S_DIV_X;
          end
        end
        S_DIV_X: begin
          if (div_done) begin
            q0x   <= div_quotient[DELTA_W-1:0];
            r0x   <= div_remainder[STEP_W-1:0];
            state <= S_DIV_Y;
          end
        end
        S_DIV_Y: begin
          if (div_done) begin
            q0y   <= div_quotient[DELTA_W-1:0];
            r0y   <= div_remainder[STEP_W-1:0];
            state <= S_DIV_D;
          end
        end
        S_DIV_D: begin
          if (div_done) begin
            q0d   <= div_quotient[DUR_W-1:0];
            r0d   <= div_remainder[STEP_W-1:0];
            rx    <= '0;
            ry    <= '0;
            rd    <= '0;
            qd    <= '0;
            k     <= STEP_W'(1);
            state <= S_SLICE;
          end
        end
        S_SLICE: begin
          slice.slice_x     <= val_x;
          slice.slice_y     <= val_y;
          slice.send_report <= (val_x != '0) || (val_y != '0);
          slice.due_ms      <= due_next;
          slice.last_slice  <= (k == steps);
          rx <= carry_x ? STEP_W'(sum_x - {1'b0, steps}) : sum_x[STEP_W-1:0];
          ry <= carry_y ? STEP_W'(sum_y - {1'b0, steps}) : sum_y[STEP_W-1:0];
          rd <= carry_d ? STEP_W'(sum_d - {1'b0, steps}) : sum_d[STEP_W-1:0];
          qd <= due_next;
          if (k == steps) begin
            state <= S_IDLE;
          end else begin
            k <= k + STEP_W'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hdl/pms_checker.sv
// ----------------------------------------------------------------------------
// Pointer move slicer checker
// Port-level checks on the slicer core, attached by a bind statement.
// ----------------------------------------------------------------------------
module pms_checker import pms_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     busy,
  input logic     slice_valid,
  input pms_out_t slice
);

  a_quiet_after_reset: assert property (@(posedge clk)
    rst |=> !slice_valid && !busy)
    else $error("Slice or busy seen right after reset.");

  a_report_flag: assert property (@(posedge clk) disable iff (rst)
    slice_valid |-> slice.send_report == ((slice.slice_x != 0) || (slice.slice_y != 0)))
    else $error("Report flag does not match the slice delta.");

  a_slices_contiguous: assert property (@(posedge clk) disable iff (rst)
    slice_valid && !slice.last_slice |=> slice_valid)
    else $error("Gap inside the slices of one move.");

  a_due_rising: assert property (@(posedge clk) disable iff (rst)
    slice_valid && !slice.last_slice |=> slice.due_ms >= $past(slice.due_ms))
    else $error("Due time went backward within a move.");

endmodule

bind pointer_move_slicer_core pms_checker u_pms_checker (
  .clk         (clk),
  .rst         (rst),
  .busy        (busy),
  .slice_valid (slice_valid),
  .slice       (slice)
);

FILE: dv/pointer_move_slicer_core_tb.sv
// ----------------------------------------------------------------------------
// Pointer move slicer core testbench
// Sends pointer moves under a range of pacing settings and checks every
// slice against a predictor of the step count, the per-axis truncated
// deltas and the due times, in order, one expected slice per transfer out.
// ----------------------------------------------------------------------------
module pointer_move_slicer_core_tb;
  import pms_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int MAX_SLICES = 64;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  pms_in_t               move;
  logic                  slice_valid;
  pms_out_t              slice;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  logic [POLL_W-1:0] poll_setting;
  logic [PACE_W-1:0] num_setting;
  logic [PACE_W-1:0] den_setting;

  pms_out_t pending_slices[$];
  pms_out_t want_slice;
  int mismatches;
  int moves_sent;
  int slices_checked;
  int reg_writes;

  pointer_move_slicer_core #(
    .MAX_STEPS(MAX_SLICES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .move(move),
    .slice_valid(slice_valid),
    .slice(slice),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("ERROR at %0t: %s", $time, what);
  endtask

  function automatic pms_in_t make_move(input int dx, input int dy, input int dur);
    pms_in_t m;
    m.delta_x = dx[DELTA_W-1:0];
    m.delta_y = dy[DELTA_W-1:0];
    m.duration_ms = dur[DUR_W-1:0];
    return m;
  endfunction

  function automatic void predict_slices(input pms_in_t m);
    int dx, dy, ax, ay, span, dur, steps, poll, num, cap;
    int k, cx, cy, sx, sy, done_x, done_y, due;
    pms_out_t s;
    dx = int'($signed(m.delta_x));
    dy = int'($signed(m.delta_y));
    dur = int'(m.duration_ms);
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    span = ax > ay ? ax : ay;
    if (span == 0) begin
      s.slice_x = '0;
      s.slice_y = '0;
      s.send_report = 1'b0;
      s.due_ms = m.duration_ms;
      s.last_slice = 1'b1;
      pending_slices.push_back(s);
      return;
    end
    steps = dur < span ? dur : span;
    if (steps == 0) steps = 1;
    poll = poll_setting != 0 ? int'(poll_setting) : 1;
    num = num_setting != 0 ? int'(num_setting) : 1;
    cap = (dur * int'(den_setting)) / (poll * num);
    if (cap == 0) cap = 1;
    if (steps > cap) steps = cap;
    if (steps > MAX_SLICES) steps = MAX_SLICES;
    done_x = 0;
    done_y = 0;
    for (k = 1; k <= steps; k++) begin
      cx = (dx * k) / steps;
      cy = (dy * k) / steps;
      sx = cx - done_x;
      sy = cy - done_y;
      done_x = cx;
      done_y = cy;
      due = (dur * k) / steps;
      s.slice_x = sx[DELTA_W-1:0];
      s.slice_y = sy[DELTA_W-1:0];
      s.send_report = (sx != 0) || (sy != 0);
      s.due_ms = due[DUR_W-1:0];
      s.last_slice = (k == steps);
      pending_slices.push_back(s);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && slice_valid) begin
      if (pending_slices.size() == 0) begin
        report_mismatch("slice transfer with no slice expected");
      end else begin
        want_slice = pending_slices.pop_front();
        slices_checked++;
        if (slice.slice_x !== want_slice.slice_x)
          report_mismatch($sformatf("slice_x got %0d want %0d",
                                    $signed(slice.slice_x), $signed(want_slice.slice_x)));
        if (slice.slice_y !== want_slice.slice_y)
          report_mismatch($sformatf("slice_y got %0d want %0d",
                                    $signed(slice.slice_y), $signed(want_slice.slice_y)));
        if (slice.send_report !== want_slice.send_report)
          report_mismatch($sformatf("send_report got %b want %b",
                                    slice.send_report, want_slice.send_report));
        if (slice.due_ms !== want_slice.due_ms)
          report_mismatch($sformatf("due_ms got %0d want %0d",
                                    slice.due_ms, want_slice.due_ms));
        if (slice.last_slice !== want_slice.last_slice)
          report_mismatch($sformatf("last_slice got %b want %b",
                                    slice.last_slice, want_slice.last_slice));
      end
    end
  end

  // Called at a falling edge; returns at a falling edge with start still high
  // when the gap is zero, so the next transfer can follow back to back.
  task automatic send_move(input pms_in_t m, input int gap);
    start = 1'b1;
    move = m;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_slices(m);
    moves_sent++;
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic wait_idle();
    start = 1'b0;
    while (pending_slices.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    reg_writes++;
    case (idx)
      CFG_POLL_INTERVAL: poll_setting = data;
      CFG_PACE_NUM:      num_setting = data[PACE_W-1:0];
      CFG_PACE_DEN:      den_setting = data[PACE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_pacing(input int poll, input int num, input int den);
    write_reg(CFG_POLL_INTERVAL, poll[CFG_DATA_W-1:0]);
    write_reg(CFG_PACE_NUM, num[CFG_DATA_W-1:0]);
    write_reg(CFG_PACE_DEN, den[CFG_DATA_W-1:0]);
  endtask

  function automatic pms_in_t random_move();
    int r, dx, dy, dur;
    int edges[5];
    edges = '{-128, 127, -1, 1, 0};
    r = $urandom_range(0, 99);
    if (r < 5) begin
      dx = 0;
      dy = 0;
    end else if (r < 15) begin
      dx = edges[$urandom_range(0, 4)];
      dy = edges[$urandom_range(0, 4)];
    end else begin
      dx = $urandom_range(0, 255);
      dy = $urandom_range(0, 255);
    end
    r = $urandom_range(0, 99);
    if (r < 10) dur = 0;
    else if (r < 50) dur = $urandom_range(1, 150);
    else if (r < 80) dur = $urandom_range(151, 5000);
    else dur = $urandom_range(0, 65535);
    return make_move(dx, dy, dur);
  endfunction

  task automatic test_reset_defaults();
    send_move(make_move(0, 0, 0), 0);
    send_move(make_move(0, 0, 65535), 1);
    send_move(make_move(5, -3, 0), 0);
    send_move(make_move(-128, 127, 0), 2);
    send_move(make_move(127, -128, 65535), 0);
    send_move(make_move(-128, -128, 65535), 0);
    send_move(make_move(1, 0, 1), 5);
    send_move(make_move(0, -1, 65535), 0);
    send_move(make_move(100, -37, 7), 0);
    send_move(make_move(-5, 90, 200), 1);
    send_move(make_move(3, 3, 3), 0);
    wait_idle();
  endtask

  task automatic test_pacing_extremes();
    // Slowest pacing: the cap falls to a few steps or to one.
    write_pacing(255, 15, 1);
    send_move(make_move(127, -100, 65535), 0);
    send_move(make_move(-64, 64, 3000), 0);
    send_move(make_move(10, 0, 4000), 1);
    wait_idle();
    // Zero interval and numerator act as one; the cap exceeds sixteen bits.
    write_pacing(0, 0, 15);
    send_move(make_move(-128, 5, 5000), 0);
    send_move(make_move(50, -50, 40), 0);
    wait_idle();
    // A zero denominator forces a single slice.
    write_reg(CFG_PACE_DEN, 8'h00);
    send_move(make_move(127, 127, 65535), 2);
    send_move(make_move(-3, 2, 100), 0);
    wait_idle();
    // Upper data bits are dropped for the narrow registers, and the spare
    // index changes nothing.
    write_reg(CFG_PACE_DEN, 8'hF3);
    write_reg(CFG_PACE_NUM, 8'h21);
    write_reg(CFG_POLL_INTERVAL, 8'h01);
    write_reg(CFG_UNUSED, 8'hAA);
    send_move(make_move(77, -120, 1000), 0);
    send_move(make_move(-1, 1, 2), 0);
    wait_idle();
  endtask

  task automatic test_random_moves();
    int phase, i;
    for (phase = 0; phase < 7; phase++) begin
      if (phase == 0) write_pacing(1, 1, 15);
      else if (phase == 1) write_pacing(255, 15, 1);
      else if ($urandom_range(0, 2) == 0)
        write_pacing($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
      else
        write_pacing($urandom_range(0, 8), $urandom_range(0, 255), $urandom_range(0, 255));
      for (i = 0; i < 60; i++)
        send_move(random_move(), (phase == 3) ? 0 : pick_gap());
      wait_idle();
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    move = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_POLL_INTERVAL;
    cfg_data = '0;
    poll_setting = 8'd1;
    num_setting = 4'd1;
    den_setting = 4'd1;
    mismatches = 0;
    moves_sent = 0;
    slices_checked = 0;
    reg_writes = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    test_reset_defaults();
    test_pacing_extremes();
    test_random_moves();

    wait_idle();
    repeat (200) @(posedge clk);
    $display("Sent %0d moves and checked %0d slices over %0d register writes,",
             moves_sent, slices_checked, reg_writes);
    $display("from zero moves and zero durations to the full pacing range.");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
